FILE: design/rgb_linear_crossfade_core_defines.svh
// Assertion macros shared by the cross-fade RTL
`ifndef RGB_LINEAR_CROSSFADE_CORE_DEFINES_SVH
`define RGB_LINEAR_CROSSFADE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low
`define RLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rlc_pkg.sv
// Types and constants for the RGB linear cross-fade block
package rlc_pkg;

    localparam int CH_W       = 8;
    localparam int NSTEP_W    = 7;
    localparam int COORD_W    = 8;
    localparam int COORD_BITS = 8;
    localparam int NUM_LANES  = 3;
    localparam int DIV_STEPS  = CH_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [NSTEP_W-1:0] MAX_STEPS   = NSTEP_W'(64);
    localparam logic [NSTEP_W-1:0] RESET_STEPS = NSTEP_W'(16);
    localparam logic [COORD_W-1:0] COORD_MASK  = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [CH_W-1:0]    from_red;
        logic [CH_W-1:0]    from_green;
        logic [CH_W-1:0]    from_blue;
        logic [CH_W-1:0]    to_red;
        logic [CH_W-1:0]    to_green;
        logic [CH_W-1:0]    to_blue;
    } rlc_item_t;

    typedef struct packed {
        logic [NSTEP_W-1:0] frame_index;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CH_W-1:0]    out_red;
        logic [CH_W-1:0]    out_green;
        logic [CH_W-1:0]    out_blue;
        logic               last_of_run;
    } rlc_result_t;

    // sequencer to lanes
    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
        logic last;
    } rlc_lane_ctrl_t;

    // sequencer to merge stage
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [NSTEP_W-1:0] frame;
    } rlc_emit_t;

endpackage

FILE: design/rgb_linear_crossfade_core.sv
// Top level of the RGB linear cross-fade block: sequencer, three channel lanes, merge stage
//
// A pixel (position, source colour, destination colour) is taken on a clock edge with start
// high and busy low. The block then produces num_steps results, one per cycle, on the result
// port marked by strobe, each for exactly one cycle: frames 1 .. num_steps-1 carry
// from + s*step per channel, where step = (to - from) / num_steps truncated toward zero, and
// the final frame carries the exact destination colour with last_of_run set. The receiver
// cannot stall, so it must take one transfer every cycle that strobe is high.
// After acceptance the three lanes run a serial divide (one quotient bit a cycle), then step
// out one frame a cycle; a new pixel may be accepted in the cycle of the final frame.
// Results appear on the port in the cycle after the lanes produce them.
// num_steps of 0 acts as 1, values above 64 act as 64. It is sampled when a pixel is
// accepted; write it only while the block is idle.
module rgb_linear_crossfade_core import rlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [NSTEP_W-1:0] cfg_data,
    input  logic               start,
    input  rlc_item_t          item,
    output logic               busy,
    output rlc_result_t        result,
    output logic               strobe
);

    `include "rgb_linear_crossfade_core_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    state_t                 state_reg;
    state_t                 state_next;
    logic [NSTEP_W-1:0]     num_steps_reg;
    logic [NSTEP_W-1:0]     n_eff;
    logic [NSTEP_W-1:0]     n_reg;
    logic [NSTEP_W-1:0]     s_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [COORD_W-1:0]     x_reg;
    logic [COORD_W-1:0]     y_reg;
    logic                   accept;
    logic                   emit_last;
    rlc_lane_ctrl_t         lane_ctrl;
    rlc_emit_t              emit;

    logic [NUM_LANES-1:0][CH_W-1:0] lane_from;
    logic [NUM_LANES-1:0][CH_W-1:0] lane_to;
    logic [NUM_LANES-1:0][CH_W-1:0] lane_colour;

    // register clamped at use: zero means one frame, anything past the limit means the limit
    always_comb
    begin
        if (num_steps_reg == '0)
        begin
            n_eff = NSTEP_W'(1);
        end
        else if (num_steps_reg > MAX_STEPS)
        begin
            n_eff = MAX_STEPS;
        end
        else
        begin
            n_eff = num_steps_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_steps_reg <= RESET_STEPS;
        end
        else if (cfg_we)
        begin
            num_steps_reg <= cfg_data;
        end
    end

    // final frame frees the input side so the next divide overlaps nothing but this cycle
    assign emit_last = (state_reg == ST_EMIT) && (s_reg == n_reg);
    assign busy      = !((state_reg == ST_IDLE) || emit_last);
    assign accept    = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = accept ? ST_DIVIDE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= RESET_STEPS;
            s_reg       <= NSTEP_W'(1);
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                n_reg       <= n_eff;
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                div_cnt_reg <= DIV_CNT_W'(div_cnt_reg + 1'b1);
            end
            // frame counter restarts at 1 for each pixel
            if (state_reg == ST_DIVIDE)
            begin
                s_reg <= NSTEP_W'(1);
            end
            else if ((state_reg == ST_EMIT) && !emit_last)
            begin
                s_reg <= NSTEP_W'(s_reg + 1'b1);
            end
        end
    end

    // coordinates are payload only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= item.pixel_x;
            y_reg <= item.pixel_y;
        end
    end

    assign lane_ctrl.load     = accept;
    assign lane_ctrl.div_step = (state_reg == ST_DIVIDE);
    assign lane_ctrl.advance  = (state_reg == ST_EMIT);
    assign lane_ctrl.last     = emit_last;

    assign emit.valid = (state_reg == ST_EMIT);
    assign emit.last  = emit_last;
    assign emit.frame = s_reg;

    assign lane_from[0] = item.from_red;
    assign lane_from[1] = item.from_green;
    assign lane_from[2] = item.from_blue;
    assign lane_to[0]   = item.to_red;
    assign lane_to[1]   = item.to_green;
    assign lane_to[2]   = item.to_blue;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rlc_lane u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .divisor (n_reg),
            .from_c  (lane_from[g]),
            .to_c    (lane_to[g]),
            .colour  (lane_colour[g])
        );
    end

    rlc_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .x           (x_reg),
        .y           (y_reg),
        .lane_colour (lane_colour),
        .result      (result),
        .strobe      (strobe)
    );

    `RLC_ASSERT_NXT(a_accept_divides, accept,
        (state_reg == ST_DIVIDE) && (div_cnt_reg == '0), "accepted pixel did not start a divide")
    `RLC_ASSERT_IMP(a_frame_in_range, state_reg == ST_EMIT,
        (s_reg != '0) && (s_reg <= n_reg), "frame counter outside 1..num_steps")
    `RLC_ASSERT_IMP(a_steps_clamped, state_reg != ST_IDLE,
        (n_reg != '0) && (n_reg <= MAX_STEPS), "latched step count not clamped")
    `RLC_ASSERT_NXT(a_last_delivered, emit_last,
        strobe && result.last_of_run && (result.frame_index == $past(n_reg)),
        "final frame not delivered with its marker")
    `RLC_ASSERT_IMP(a_mid_run_busy, strobe && !result.last_of_run,
        state_reg == ST_EMIT, "non-final transfer outside the emit phase")

endmodule

FILE: design/rlc_lane.sv
// One colour channel: serial step divider followed by a stepping accumulator
module rlc_lane import rlc_pkg::*;
(
    input  logic                clk,
    input  rlc_lane_ctrl_t      ctrl,
    input  logic [NSTEP_W-1:0]  divisor,
    input  logic [CH_W-1:0]     from_c,
    input  logic [CH_W-1:0]     to_c,
    output logic [CH_W-1:0]     colour
);

    logic [CH_W:0]      diff;
    logic [CH_W:0]      diff_neg;
    logic [CH_W-1:0]    mag;
    logic [CH_W-1:0]    to_reg;
    logic [CH_W-1:0]    acc_reg;
    logic [CH_W-1:0]    acc_next;
    logic [CH_W-1:0]    dq_reg;
    logic [NSTEP_W-1:0] rem_reg;
    logic               neg_reg;
    logic [NSTEP_W:0]   trial;
    logic               trial_ge;
    logic [NSTEP_W-1:0] rem_next;
    logic [CH_W-1:0]    step;

    assign diff     = {1'b0, to_c} - {1'b0, from_c};
    assign diff_neg = -diff;
    assign mag      = diff[CH_W] ? diff_neg[CH_W-1:0] : diff[CH_W-1:0];

    // restoring division, one quotient bit a cycle, MSB first
    assign trial    = {rem_reg, dq_reg[CH_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign rem_next = trial_ge ? NSTEP_W'(trial - {1'b0, divisor}) : trial[NSTEP_W-1:0];

    // quotient truncated toward zero, sign restored; sums wrap mod 256
    assign step     = neg_reg ? CH_W'(-dq_reg) : dq_reg;
    assign acc_next = CH_W'(acc_reg + step);
    assign colour   = ctrl.last ? to_reg : acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            to_reg  <= to_c;
            acc_reg <= from_c;
            dq_reg  <= mag;
            rem_reg <= '0;
            neg_reg <= diff[CH_W];
        end
        else if (ctrl.div_step)
        begin
            dq_reg  <= {dq_reg[CH_W-2:0], trial_ge};
            rem_reg <= rem_next;
        end
        else if (ctrl.advance)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: design/rlc_merge.sv
// Merge stage: gathers lane colours, frame number and coordinates into the result register
module rlc_merge import rlc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlc_emit_t                     emit,
    input  logic [COORD_W-1:0]            x,
    input  logic [COORD_W-1:0]            y,
    input  logic [NUM_LANES-1:0][CH_W-1:0] lane_colour,
    output rlc_result_t                   result,
    output logic                          strobe
);

    rlc_result_t result_reg;
    rlc_result_t result_next;
    logic        strobe_reg;

    always_comb
    begin
        result_next.frame_index = emit.frame;
        result_next.out_x       = x & COORD_MASK;
        result_next.out_y       = y & COORD_MASK;
        result_next.out_red     = lane_colour[0];
        result_next.out_green   = lane_colour[1];
        result_next.out_blue    = lane_colour[2];
        result_next.last_of_run = emit.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

FILE: dv/rgb_linear_crossfade_core_test.sv
// Self-checking testbench for the RGB linear cross-fade core
`timescale 1ns / 100ps

module rgb_linear_crossfade_core_test import rlc_pkg::*;
();

    localparam int FADE_RESET   = 16;
    localparam int FADE_MAX     = 64;
    localparam int RANDOM_FADES = 290;
    localparam int BURST_FADES  = 60;
    localparam int QUIET_LIMIT  = 2000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [NSTEP_W-1:0]  cfg_data = '0;
    logic                start = 1'b0;
    rlc_item_t           item = '0;
    logic                busy;
    rlc_result_t         result;
    logic                strobe;

    // model copy of the fade length register
    logic [NSTEP_W-1:0]  fade_len = NSTEP_W'(FADE_RESET);
    rlc_result_t         pending_frames[$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  idle_pct = 8;

    rgb_linear_crossfade_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .result   (result),
        .strobe   (strobe)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        end
    endtask

    // one interpolated channel: step truncates toward zero, result wraps to 8 bits
    function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] src,
                                                      input logic [CH_W-1:0] dst,
                                                      input int frames, input int s);
        int a;
        int b;
        int v;
        a = src;
        b = dst;
        v = a + s * ((b - a) / frames);
        return v[CH_W-1:0];
    endfunction

    function automatic void queue_fade(input rlc_item_t px, input logic [NSTEP_W-1:0] setting);
        int          frames;
        rlc_result_t f;
        // zero acts as one, anything above the cap acts as the cap
        frames = (setting == 0) ? 1 : ((setting > FADE_MAX) ? FADE_MAX : int'(setting));
        for (int s = 1; s <= frames; s++)
        begin
            f.frame_index = NSTEP_W'(s);
            f.out_x       = px.pixel_x;
            f.out_y       = px.pixel_y;
            if (s == frames)
            begin
                f.out_red     = px.to_red;
                f.out_green   = px.to_green;
                f.out_blue    = px.to_blue;
                f.last_of_run = 1'b1;
            end
            else
            begin
                f.out_red     = blend_channel(px.from_red, px.to_red, frames, s);
                f.out_green   = blend_channel(px.from_green, px.to_green, frames, s);
                f.out_blue    = blend_channel(px.from_blue, px.to_blue, frames, s);
                f.last_of_run = 1'b0;
            end
            pending_frames.push_back(f);
        end
    endfunction

    task automatic check_frame(input rlc_result_t got);
        rlc_result_t want;
        if (pending_frames.size() == 0)
        begin
            report_mismatch($sformatf("unexpected frame %0d for pixel (%0d,%0d)",
                                      got.frame_index, got.out_x, got.out_y));
            return;
        end
        want = pending_frames.pop_front();
        compare_field("frame_index", 8'(got.frame_index), 8'(want.frame_index));
        compare_field("out_x", got.out_x, want.out_x);
        compare_field("out_y", got.out_y, want.out_y);
        compare_field("out_red", got.out_red, want.out_red);
        compare_field("out_green", got.out_green, want.out_green);
        compare_field("out_blue", got.out_blue, want.out_blue);
        compare_field("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
    endtask

    // Samples pre-edge values: register writes, pixel transfers, result transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fade_len     = NSTEP_W'(FADE_RESET);
            quiet_cycles = 0;
        end
        else
        begin
            if (strobe)
            begin
                check_frame(result);
            end
            if (cfg_we)
            begin
                fade_len = cfg_data;
            end
            if (start && !busy)
            begin
                queue_fade(item, fade_len);
            end
            if (strobe || cfg_we || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [CH_W-1:0] random_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rlc_item_t random_pixel();
        rlc_item_t px;
        px.pixel_x    = COORD_W'($urandom_range(0, 255));
        px.pixel_y    = COORD_W'($urandom_range(0, 255));
        px.from_red   = random_level();
        px.from_green = random_level();
        px.from_blue  = random_level();
        px.to_red     = random_level();
        px.to_green   = random_level();
        px.to_blue    = random_level();
        return px;
    endfunction

    function automatic rlc_item_t pixel(input int x, input int y,
                                        input int fr, input int fg, input int fb,
                                        input int tr, input int tg, input int tb);
        rlc_item_t px;
        px = '{COORD_W'(x), COORD_W'(y), CH_W'(fr), CH_W'(fg), CH_W'(fb),
               CH_W'(tr), CH_W'(tg), CH_W'(tb)};
        return px;
    endfunction

    // Returns in the step of the accepting edge with start still high
    task automatic send_pixel(input rlc_item_t px);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 48)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= px;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain_frames();
        start <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0) @(posedge clk);
    endtask

    // register is only written once the block has gone quiet
    task automatic set_fade_length(input int value);
        drain_frames();
        cfg_we   <= 1'b1;
        cfg_data <= NSTEP_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic test_reset_length();
        send_pixel(pixel(0, 0, 0, 0, 0, 255, 255, 255));
        send_pixel(pixel(255, 255, 255, 255, 255, 0, 0, 0));
        send_pixel(pixel(170, 85, 12, 200, 99, 12, 200, 99));
        send_pixel(pixel(85, 170, 0, 255, 128, 255, 0, 127));
    endtask

    task automatic test_length_extremes();
        set_fade_length(1);
        send_pixel(pixel(1, 2, 10, 20, 30, 240, 250, 5));
        send_pixel(pixel(254, 0, 255, 0, 255, 0, 255, 0));
        // zero behaves as a single frame
        set_fade_length(0);
        send_pixel(pixel(0, 255, 0, 255, 0, 255, 0, 255));
        send_pixel(pixel(128, 64, 33, 44, 55, 66, 77, 88));
        set_fade_length(FADE_MAX);
        send_pixel(pixel(0, 255, 0, 255, 7, 255, 0, 200));
        send_pixel(pixel(3, 4, 100, 100, 100, 101, 99, 100));
        // beyond the cap: clamps to the longest fade
        set_fade_length(127);
        send_pixel(pixel(255, 0, 255, 0, 128, 0, 255, 127));
        set_fade_length(FADE_MAX + 1);
        send_pixel(pixel(16, 32, 1, 254, 60, 200, 3, 61));
        set_fade_length(2);
        send_pixel(pixel(7, 7, 0, 255, 1, 255, 0, 0));
        send_pixel(pixel(9, 9, 3, 250, 128, 0, 5, 129));
        // negative odd step, truncation toward zero
        set_fade_length(3);
        send_pixel(pixel(100, 200, 10, 0, 250, 0, 10, 240));
    endtask

    task automatic test_random_fades();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_FADES)
        begin
            case ($urandom_range(0, 9))
                0:       set_fade_length(0);
                1:       set_fade_length(1);
                2:       set_fade_length(FADE_MAX);
                3:       set_fade_length($urandom_range(FADE_MAX + 1, 127));
                default: set_fade_length($urandom_range(2, 20));
            endcase
            burst = $urandom_range(20, 40);
            repeat (burst)
            begin
                send_pixel(random_pixel());
            end
            sent += burst;
        end
    endtask

    // a long stretch with start held high throughout
    task automatic test_back_to_back();
        set_fade_length($urandom_range(1, 8));
        idle_pct = 0;
        repeat (BURST_FADES)
        begin
            send_pixel(random_pixel());
        end
        idle_pct = 8;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_length();
        test_length_extremes();
        test_random_fades();
        test_back_to_back();
        drain_frames();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
